>>> design/c2c_pkg.sv
// shared types, constants and datapath commands for the coordinate-to-csr store
package c2c_pkg;

  localparam int MAX_NZ   = 1024;
  localparam int NZ_AW    = $clog2(MAX_NZ);
  localparam int CNT_W    = NZ_AW + 1;
  localparam int MAX_ROWS = 256;
  localparam int MAX_COLS = 256;
  localparam int RS_AW    = $clog2(MAX_ROWS + 1);
  localparam int ROW_W    = 8;
  localparam int COL_W    = 8;
  localparam int VAL_W    = 64;
  localparam int CFG_W    = 9;
  localparam int CFG_IW   = 1;

  localparam logic [2:0] MODE_CLEAR    = 3'd0;
  localparam logic [2:0] MODE_LOAD     = 3'd1;
  localparam logic [2:0] MODE_BUILD    = 3'd2;
  localparam logic [2:0] MODE_RD_ENTRY = 3'd3;
  localparam logic [2:0] MODE_RD_PTR   = 3'd4;
  localparam logic [2:0] MODE_LOOKUP   = 3'd5;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_RANGE     = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_NOT_BUILT = 2'd3;

  localparam logic [CFG_IW-1:0] REG_NUM_ROWS = 1'd0;
  localparam logic [CFG_IW-1:0] REG_NUM_COLS = 1'd1;

  typedef struct packed {
    logic [2:0]       mode;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] column;
    logic [VAL_W-1:0] value;
    logic [CNT_W-1:0] index;
  } in_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [VAL_W-1:0] data_value;
    logic [ROW_W-1:0] entry_row;
    logic [COL_W-1:0] entry_column;
    logic [CNT_W-1:0] row_offset;
    logic             found;
    logic [CNT_W-1:0] entry_count;
  } out_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_TAKE, OP_FINISH, OP_RD_ENTRY, OP_RD_PTR, OP_EMIT_READ,
    OP_LK_START, OP_LK_END, OP_LK_BOUND, OP_LK_READ, OP_LK_NEXT, OP_LK_HIT, OP_LK_MISS,
    OP_BLD_START, OP_BC_CLR, OP_CNT_CHK, OP_CNT_WR, OP_BLD_FAIL,
    OP_PFX_WR, OP_PFX_END, OP_SCT_CUR, OP_SCT_WR, OP_BLD_DONE
  } dp_op_t;

  typedef struct packed {
    logic [2:0] mode;
    logic       pre_ok;
    logic       out_busy;
    logic       k_done;
    logic       r_done;
    logic       err;
    logic       lk_more;
    logic       lk_hit;
  } dp_flags_t;

endpackage

>>> design/c2c_ctrl.sv
// sequencer for clear, load, read, lookup and the build passes (count clear, count, prefix sum, scatter)
module c2c_ctrl import c2c_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  dp_flags_t flags,
  output dp_op_t    op
);

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_EMIT, S_LK_A, S_LK_B, S_LK_RD, S_LK_CMP,
    S_CLR, S_CNT_RD, S_CNT_CHK, S_CNT_WR, S_PFX_RD, S_PFX_WR,
    S_SCT_RD, S_SCT_CUR, S_SCT_WR
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    op        = OP_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op        = OP_TAKE;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!flags.out_busy) begin
          if (flags.mode == MODE_BUILD) begin
            op        = OP_BLD_START;
            state_nxt = S_CLR;
          end else if (flags.pre_ok && flags.mode == MODE_LOOKUP) begin
            op        = OP_LK_START;
            state_nxt = S_LK_A;
          end else if (flags.pre_ok && flags.mode == MODE_RD_ENTRY) begin
            op        = OP_RD_ENTRY;
            state_nxt = S_EMIT;
          end else if (flags.pre_ok && flags.mode == MODE_RD_PTR) begin
            op        = OP_RD_PTR;
            state_nxt = S_EMIT;
          end else begin
            op        = OP_FINISH;
            state_nxt = S_IDLE;
          end
        end
      end
      S_EMIT: begin
        op        = OP_EMIT_READ;
        state_nxt = S_IDLE;
      end
      S_LK_A: begin
        op        = OP_LK_END;
        state_nxt = S_LK_B;
      end
      S_LK_B: begin
        op        = OP_LK_BOUND;
        state_nxt = S_LK_RD;
      end
      S_LK_RD: begin
        if (flags.lk_more) begin
          op        = OP_LK_READ;
          state_nxt = S_LK_CMP;
        end else begin
          op        = OP_LK_MISS;
          state_nxt = S_IDLE;
        end
      end
      S_LK_CMP: begin
        if (flags.lk_hit) begin
          op        = OP_LK_HIT;
          state_nxt = S_IDLE;
        end else begin
          op        = OP_LK_NEXT;
          state_nxt = S_LK_RD;
        end
      end
      S_CLR: begin
        op = OP_BC_CLR;
        if (flags.r_done) state_nxt = S_CNT_RD;
      end
      S_CNT_RD: begin
        if (flags.k_done) begin
          if (flags.err) begin
            op        = OP_BLD_FAIL;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_PFX_RD;
          end
        end else begin
          state_nxt = S_CNT_CHK;
        end
      end
      S_CNT_CHK: begin
        op        = OP_CNT_CHK;
        state_nxt = S_CNT_WR;
      end
      S_CNT_WR: begin
        op        = OP_CNT_WR;
        state_nxt = S_CNT_RD;
      end
      S_PFX_RD: begin
        if (flags.r_done) begin
          op        = OP_PFX_END;
          state_nxt = S_SCT_RD;
        end else begin
          state_nxt = S_PFX_WR;
        end
      end
      S_PFX_WR: begin
        op        = OP_PFX_WR;
        state_nxt = S_PFX_RD;
      end
      S_SCT_RD: begin
        if (flags.k_done) begin
          op        = OP_BLD_DONE;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_SCT_CUR;
        end
      end
      S_SCT_CUR: begin
        op        = OP_SCT_CUR;
        state_nxt = S_SCT_WR;
      end
      S_SCT_WR: begin
        op        = OP_SCT_WR;
        state_nxt = S_SCT_RD;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> design/c2c_dp.sv
// stores, counters, config registers and result register
module c2c_dp import c2c_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  dp_op_t            op,
  input  in_t               in_data,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  input  logic              out_stall,
  output dp_flags_t         flags,
  output logic              out_valid,
  output out_t              out_data
);

  in_t              item_r;
  logic [CFG_W-1:0] num_rows_r, num_cols_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             built_r;
  logic [CNT_W-1:0] k_r, acc_r, ptr_r, end_r;
  logic [RS_AW-1:0] r_r;
  logic             err_r;
  logic [ROW_W-1:0] cur_row_r;
  logic [COL_W-1:0] cur_col_r;
  logic [VAL_W-1:0] cur_val_r;
  out_t             out_r, out_nxt;
  logic             out_valid_r;

  logic [ROW_W-1:0] coo_row_mem [MAX_NZ];
  logic [COL_W-1:0] coo_col_mem [MAX_NZ];
  logic [VAL_W-1:0] coo_val_mem [MAX_NZ];
  logic [ROW_W-1:0] csr_row_mem [MAX_NZ];
  logic [COL_W-1:0] csr_col_mem [MAX_NZ];
  logic [VAL_W-1:0] csr_val_mem [MAX_NZ];
  logic [CNT_W-1:0] cnt_mem     [MAX_ROWS + 1];
  logic [CNT_W-1:0] rs_mem      [MAX_ROWS + 1];

  logic [ROW_W-1:0] coo_row_q, csr_row_q;
  logic [COL_W-1:0] coo_col_q, csr_col_q;
  logic [VAL_W-1:0] coo_val_q, csr_val_q;
  logic [CNT_W-1:0] cnt_q, rs_q;

  logic [RS_AW-1:0] nr, nc;
  logic [1:0]       pre_status;
  logic             emit;
  logic             coo_we, csr_we, cnt_we, rs_we;
  logic [NZ_AW-1:0] csr_ra;
  logic [RS_AW-1:0] cnt_ra, cnt_wa, rs_ra, rs_wa;
  logic [CNT_W-1:0] cnt_wd, rs_wd;

  // effective sizes, clipped to the store limits
  assign nr = (num_rows_r > CFG_W'(MAX_ROWS)) ? RS_AW'(MAX_ROWS) : RS_AW'(num_rows_r);
  assign nc = (num_cols_r > CFG_W'(MAX_COLS)) ? RS_AW'(MAX_COLS) : RS_AW'(num_cols_r);

  always_comb begin
    pre_status = ST_OK;
    unique case (item_r.mode)
      MODE_CLEAR, MODE_BUILD: pre_status = ST_OK;
      MODE_LOAD: begin
        if (RS_AW'(item_r.row) >= nr || RS_AW'(item_r.column) >= nc) pre_status = ST_RANGE;
        else if (count_r == CNT_W'(MAX_NZ)) pre_status = ST_FULL;
      end
      MODE_RD_ENTRY: begin
        if (!built_r) pre_status = ST_NOT_BUILT;
        else if (item_r.index >= count_r) pre_status = ST_RANGE;
      end
      MODE_RD_PTR: begin
        if (!built_r) pre_status = ST_NOT_BUILT;
        else if (item_r.index > CNT_W'(nr)) pre_status = ST_RANGE;
      end
      MODE_LOOKUP: begin
        if (!built_r) pre_status = ST_NOT_BUILT;
        else if (RS_AW'(item_r.row) >= nr || RS_AW'(item_r.column) >= nc)
          pre_status = ST_RANGE;
      end
      default: pre_status = ST_RANGE;
    endcase
  end

  assign coo_we = (op == OP_FINISH) && (item_r.mode == MODE_LOAD) && (pre_status == ST_OK);

  always_comb begin
    count_nxt = count_r;
    if (op == OP_FINISH && item_r.mode == MODE_CLEAR) count_nxt = '0;
    else if (coo_we) count_nxt = count_r + CNT_W'(1);
  end

  always_comb begin
    out_nxt             = '0;
    out_nxt.entry_count = count_nxt;
    unique case (op)
      OP_FINISH: out_nxt.status = pre_status;
      OP_BLD_FAIL: out_nxt.status = ST_RANGE;
      OP_EMIT_READ: begin
        if (item_r.mode == MODE_RD_ENTRY) begin
          out_nxt.data_value   = csr_val_q;
          out_nxt.entry_row    = csr_row_q;
          out_nxt.entry_column = csr_col_q;
        end else begin
          out_nxt.row_offset = rs_q;
        end
      end
      OP_LK_HIT: begin
        out_nxt.data_value = csr_val_q;
        out_nxt.found      = 1'b1;
      end
      default: out_nxt.status = ST_OK;
    endcase
  end

  assign emit = (op == OP_FINISH) || (op == OP_EMIT_READ) || (op == OP_LK_HIT) ||
                (op == OP_LK_MISS) || (op == OP_BLD_FAIL) || (op == OP_BLD_DONE);

  // memory addressing
  assign csr_ra = (op == OP_LK_READ) ? ptr_r[NZ_AW-1:0] : item_r.index[NZ_AW-1:0];
  assign cnt_ra = (op == OP_CNT_CHK || op == OP_SCT_CUR) ? RS_AW'(coo_row_q) : r_r;

  always_comb begin
    rs_ra = RS_AW'(item_r.row);
    unique case (op)
      OP_RD_PTR: rs_ra = item_r.index[RS_AW-1:0];
      OP_LK_END: rs_ra = RS_AW'(item_r.row) + RS_AW'(1);
      default:   rs_ra = RS_AW'(item_r.row);
    endcase
  end

  always_comb begin
    cnt_we = 1'b0;
    cnt_wa = r_r;
    cnt_wd = '0;
    unique case (op)
      OP_BC_CLR: cnt_we = 1'b1;
      OP_PFX_WR: begin
        cnt_we = 1'b1;
        cnt_wd = acc_r;
      end
      OP_CNT_WR, OP_SCT_WR: begin
        cnt_we = 1'b1;
        cnt_wa = RS_AW'(cur_row_r);
        cnt_wd = cnt_q + CNT_W'(1);
      end
      default: cnt_we = 1'b0;
    endcase
  end

  assign rs_we = (op == OP_BLD_START) || (op == OP_PFX_WR);
  assign rs_wa = (op == OP_PFX_WR) ? r_r + RS_AW'(1) : '0;
  assign rs_wd = (op == OP_PFX_WR) ? acc_r + cnt_q : '0;
  assign csr_we = (op == OP_SCT_WR) && (cnt_q < CNT_W'(MAX_NZ));

  always_ff @(posedge clk) begin
    if (coo_we) begin
      coo_row_mem[count_r[NZ_AW-1:0]] <= item_r.row;
      coo_col_mem[count_r[NZ_AW-1:0]] <= item_r.column;
      coo_val_mem[count_r[NZ_AW-1:0]] <= item_r.value;
    end
    coo_row_q <= coo_row_mem[k_r[NZ_AW-1:0]];
    coo_col_q <= coo_col_mem[k_r[NZ_AW-1:0]];
    coo_val_q <= coo_val_mem[k_r[NZ_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (csr_we) begin
      csr_row_mem[cnt_q[NZ_AW-1:0]] <= cur_row_r;
      csr_col_mem[cnt_q[NZ_AW-1:0]] <= cur_col_r;
      csr_val_mem[cnt_q[NZ_AW-1:0]] <= cur_val_r;
    end
    csr_row_q <= csr_row_mem[csr_ra];
    csr_col_q <= csr_col_mem[csr_ra];
    csr_val_q <= csr_val_mem[csr_ra];
  end

  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
    cnt_q <= cnt_mem[cnt_ra];
  end

  always_ff @(posedge clk) begin
    if (rs_we) rs_mem[rs_wa] <= rs_wd;
    rs_q <= rs_mem[rs_ra];
  end

  // walk counters and latched operands
  always_ff @(posedge clk) begin
    unique case (op)
      OP_TAKE: item_r <= in_data;
      OP_BLD_START: begin
        r_r   <= '0;
        err_r <= 1'b0;
        acc_r <= '0;
      end
      OP_BC_CLR: begin
        if (r_r == nr) begin
          r_r <= '0;
          k_r <= '0;
        end else begin
          r_r <= r_r + RS_AW'(1);
        end
      end
      OP_CNT_CHK: begin
        cur_row_r <= coo_row_q;
        if (RS_AW'(coo_row_q) >= nr) err_r <= 1'b1;
      end
      OP_CNT_WR, OP_SCT_WR: k_r <= k_r + CNT_W'(1);
      OP_PFX_WR: begin
        acc_r <= acc_r + cnt_q;
        r_r   <= r_r + RS_AW'(1);
      end
      OP_PFX_END: k_r <= '0;
      OP_SCT_CUR: begin
        cur_row_r <= coo_row_q;
        cur_col_r <= coo_col_q;
        cur_val_r <= coo_val_q;
      end
      OP_LK_END:   ptr_r <= rs_q;
      OP_LK_BOUND: end_r <= rs_q;
      OP_LK_NEXT:  ptr_r <= ptr_r + CNT_W'(1);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (emit) out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_rows_r  <= CFG_W'(MAX_ROWS);
      num_cols_r  <= CFG_W'(MAX_COLS);
      count_r     <= '0;
      built_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (emit) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      if (cfg_we) begin
        if (cfg_index == REG_NUM_ROWS) num_rows_r <= cfg_data;
        else num_cols_r <= cfg_data;
        built_r <= 1'b0;
      end else if (coo_we || (op == OP_FINISH && item_r.mode == MODE_CLEAR)) begin
        built_r <= 1'b0;
      end else if (op == OP_BLD_DONE) begin
        built_r <= 1'b1;
      end
    end
  end

  assign flags.mode     = item_r.mode;
  assign flags.pre_ok   = (pre_status == ST_OK);
  assign flags.out_busy = out_valid_r && out_stall;
  assign flags.k_done   = (k_r == count_r);
  assign flags.r_done   = (r_r == nr);
  assign flags.err      = err_r;
  assign flags.lk_more  = (ptr_r < end_r);
  assign flags.lk_hit   = (csr_col_q == item_r.column);

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_NZ))
    else $error("entry count beyond store depth");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> !(out_valid_r && out_stall))
    else $error("result written over a waiting word");

  a_cfg_unbuilds: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> !built_r)
    else $error("built flag survived a register write");

  a_built_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(built_r) |-> $past(op == OP_BLD_DONE))
    else $error("built flag set outside a build");
`endif

endmodule

>>> design/coo_to_csr_sparse_store_top.sv
// top level of the coordinate-to-compressed-sparse-row store
//
//  channel | dir | handshake          | word
//  in_     | in  | in_valid/in_stall   | in_data (in_t: mode, row, column, value, index)
//  out_    | out | out_valid/out_stall | out_data (out_t: status ... entry_count)
//  cfg_    | in  | cfg_we              | cfg_index, cfg_data (num_rows, num_columns)
//
// clear, load and error results are registered from the execute state; entry and pointer
// reads add one registered memory read; lookup scans the row's entries until a column match
// or the end of the row; build walks the count memory for count clear, count pass, prefix sum
// and scatter, in that order
// rst_n is synchronous; it clears the fill count and built flag, stores are not cleared
// one word is in flight at a time; a waiting result does not block taking the next word
module coo_to_csr_sparse_store_top import c2c_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_t               in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_t              out_data,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_data
);

  // command from the sequencer, status back from the datapath
  dp_op_t    op;
  dp_flags_t flags;

  c2c_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .flags    (flags),
    .op       (op)
  );

  c2c_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .op        (op),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_stall (out_stall),
    .flags     (flags),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
